>>> sv/bbf_pkg.sv
// Package with shared constants, codes and the command type of the biquad filter.
package bbf_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 30;
  localparam int COEF_W             = 32;
  localparam int STATE_W            = 48;
  localparam int STATE_FRAC         = 14;
  localparam int CFG_INDEX_W        = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_A2 = 3'd4;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_XB0  = 3'd1;
  localparam logic [2:0] MUL_XB1  = 3'd2;
  localparam logic [2:0] MUL_XB2  = 3'd3;
  localparam logic [2:0] MUL_YA1  = 3'd4;
  localparam logic [2:0] MUL_YA2  = 3'd5;

  typedef struct packed {
    logic       load_in;
    logic [2:0] mul_sel;
    logic       scale_en;
    logic       acc_en;
    logic       y_en;
    logic       t1_en;
    logic       t2_en;
    logic       d1_en;
    logic       d2_en;
    logic       out_load;
  } cmd_t;

endpackage

>>> sv/biquad_bandpass_filter.sv
// Top level of the transposed direct form II biquad section with sequencer and datapath.
// Each word steps through the sequencer from acceptance to the result word, and the next input
// word is accepted once the result word is loaded into the output register, so no word is taken
// before the last is through. The single shared 24 by 32 multiplier computes the five products.
// A stalled result holds the sequencer in its last step before the output register.
// Synchronous reset clears the state words, restores unity gain and empties the output.
module biquad_bandpass_filter #(
  parameter int SAMPLE_WIDTH   = bbf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bbf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  logic                             block_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output logic                             clipped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bbf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bbf_pkg::COEF_W-1:0]       cfg_data
);

  bbf_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  bbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bbf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample_in   (sample_in),
    .block_start (block_start),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_out  (sample_out),
    .clipped     (clipped)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output word overwritten while waiting");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.d1_en, cmd.d2_en, cmd.out_load}))
    else $error("sequencer steps overlap");

  a_load_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("output word not shown after load");

endmodule

>>> sv/bbf_ctrl.sv
// Sequencer that steps the shared multiplier and the state update for each sample.
module bbf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output bbf_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_S1   = 4'd1;
  localparam logic [3:0] ST_S2   = 4'd2;
  localparam logic [3:0] ST_S3   = 4'd3;
  localparam logic [3:0] ST_S4   = 4'd4;
  localparam logic [3:0] ST_S5   = 4'd5;
  localparam logic [3:0] ST_S6   = 4'd6;
  localparam logic [3:0] ST_S7   = 4'd7;
  localparam logic [3:0] ST_S8   = 4'd8;
  localparam logic [3:0] ST_PUSH = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_busy;

  assign in_stall = (state != ST_IDLE);
  assign out_busy = out_valid && out_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = bbf_pkg::MUL_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = ST_S1;
        end
      end
      ST_S1: begin
        cmd.mul_sel = bbf_pkg::MUL_XB0;
        state_next = ST_S2;
      end
      ST_S2: begin
        cmd.scale_en = 1'b1;
        cmd.mul_sel = bbf_pkg::MUL_XB1;
        state_next = ST_S3;
      end
      ST_S3: begin
        cmd.acc_en = 1'b1;
        cmd.scale_en = 1'b1;
        cmd.mul_sel = bbf_pkg::MUL_XB2;
        state_next = ST_S4;
      end
      ST_S4: begin
        cmd.y_en = 1'b1;
        cmd.t1_en = 1'b1;
        cmd.scale_en = 1'b1;
        state_next = ST_S5;
      end
      ST_S5: begin
        cmd.t2_en = 1'b1;
        cmd.mul_sel = bbf_pkg::MUL_YA1;
        state_next = ST_S6;
      end
      ST_S6: begin
        cmd.scale_en = 1'b1;
        cmd.mul_sel = bbf_pkg::MUL_YA2;
        state_next = ST_S7;
      end
      ST_S7: begin
        cmd.d1_en = 1'b1;
        cmd.scale_en = 1'b1;
        state_next = ST_S8;
      end
      ST_S8: begin
        cmd.d2_en = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/bbf_datapath.sv
// Datapath with coefficient registers, the shared multiplier, the state words and the output word.
module bbf_datapath #(
  parameter int SAMPLE_WIDTH   = bbf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bbf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bbf_pkg::cmd_t                        cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  input  logic                                 block_start,
  input  logic                                 cfg_we,
  input  logic [bbf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bbf_pkg::COEF_W-1:0]           cfg_data,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  output logic                                 clipped
);

  localparam int CW    = bbf_pkg::COEF_W;
  localparam int SW    = bbf_pkg::STATE_W;
  localparam int PW    = SAMPLE_WIDTH + CW;
  localparam int SHIFT = COEF_FRAC_BITS - bbf_pkg::STATE_FRAC;
  localparam int EXT_W = (PW + 2 > SW + 1) ? PW + 2 : SW + 1;
  localparam int YW    = SW + 2;

  localparam logic signed [EXT_W-1:0] HALF = EXT_W'((2 ** SHIFT) / 2);
  localparam logic signed [EXT_W-1:0] P_MAX =
    {{(EXT_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] P_MIN = ~P_MAX;
  localparam logic signed [YW-1:0] Y_HALF = YW'(2 ** (bbf_pkg::STATE_FRAC - 1));
  localparam logic signed [YW-1:0] Y_MAX =
    {{(YW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [YW-1:0] D_MAX = {{(YW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [YW-1:0] D_MIN = ~D_MAX;
  localparam logic [CW-1:0] B0_RESET = CW'(2 ** COEF_FRAC_BITS);

  logic signed [CW-1:0]           coef_b0;
  logic signed [CW-1:0]           coef_b1;
  logic signed [CW-1:0]           coef_b2;
  logic signed [CW-1:0]           coef_a1;
  logic signed [CW-1:0]           coef_a2;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] y;
  logic                           y_clip;
  logic signed [PW-1:0]           prod;
  logic signed [SW-1:0]           sc;
  logic signed [SW:0]             acc;
  logic signed [SW:0]             t1;
  logic signed [SW-1:0]           t2;
  logic signed [SW-1:0]           delay_one;
  logic signed [SW-1:0]           delay_two;

  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [CW-1:0]           mul_b;
  logic signed [EXT_W-1:0]        prod_ext;
  logic signed [EXT_W-1:0]        prod_rnd;
  logic signed [SW-1:0]           sc_next;
  logic signed [YW-1:0]           acc_rnd;
  logic signed [SAMPLE_WIDTH-1:0] y_next;
  logic                           y_clip_next;
  logic signed [YW-1:0]           d1_diff;
  logic signed [YW-1:0]           d2_diff;
  logic signed [SW-1:0]           d1_next;
  logic signed [SW-1:0]           d2_next;

  always_comb begin
    mul_a = x;
    mul_b = coef_b0;
    unique case (cmd.mul_sel)
      bbf_pkg::MUL_XB0: begin
        mul_a = x;
        mul_b = coef_b0;
      end
      bbf_pkg::MUL_XB1: begin
        mul_a = x;
        mul_b = coef_b1;
      end
      bbf_pkg::MUL_XB2: begin
        mul_a = x;
        mul_b = coef_b2;
      end
      bbf_pkg::MUL_YA1: begin
        mul_a = y;
        mul_b = coef_a1;
      end
      bbf_pkg::MUL_YA2: begin
        mul_a = y;
        mul_b = coef_a2;
      end
      default: begin
        mul_a = x;
        mul_b = coef_b0;
      end
    endcase
  end

  always_comb begin
    prod_ext = {{(EXT_W-PW){prod[PW-1]}}, prod};
    prod_rnd = (prod_ext + HALF) >>> SHIFT;
    if (prod_rnd > P_MAX) begin
      sc_next = P_MAX[SW-1:0];
    end else if (prod_rnd < P_MIN) begin
      sc_next = P_MIN[SW-1:0];
    end else begin
      sc_next = prod_rnd[SW-1:0];
    end

    acc_rnd = ($signed({acc[SW], acc}) + Y_HALF) >>> bbf_pkg::STATE_FRAC;
    y_clip_next = 1'b1;
    if (acc_rnd > Y_MAX) begin
      y_next = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (acc_rnd < Y_MIN) begin
      y_next = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_next = acc_rnd[SAMPLE_WIDTH-1:0];
      y_clip_next = 1'b0;
    end

    d1_diff = {t1[SW], t1} - {{2{sc[SW-1]}}, sc};
    if (d1_diff > D_MAX) begin
      d1_next = D_MAX[SW-1:0];
    end else if (d1_diff < D_MIN) begin
      d1_next = D_MIN[SW-1:0];
    end else begin
      d1_next = d1_diff[SW-1:0];
    end

    d2_diff = {{2{t2[SW-1]}}, t2} - {{2{sc[SW-1]}}, sc};
    if (d2_diff > D_MAX) begin
      d2_next = D_MAX[SW-1:0];
    end else if (d2_diff < D_MIN) begin
      d2_next = D_MIN[SW-1:0];
    end else begin
      d2_next = d2_diff[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= B0_RESET;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbf_pkg::REG_B0: coef_b0 <= cfg_data;
        bbf_pkg::REG_B1: coef_b1 <= cfg_data;
        bbf_pkg::REG_B2: coef_b2 <= cfg_data;
        bbf_pkg::REG_A1: coef_a1 <= cfg_data;
        bbf_pkg::REG_A2: coef_a2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (cmd.load_in && block_start) begin
        delay_one <= '0;
        delay_two <= '0;
      end
      if (cmd.d1_en) begin
        delay_one <= d1_next;
      end
      if (cmd.d2_en) begin
        delay_two <= d2_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= sample_in;
    end
    if (cmd.mul_sel != bbf_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.scale_en) begin
      sc <= sc_next;
    end
    if (cmd.acc_en) begin
      acc <= {sc[SW-1], sc} + {delay_one[SW-1], delay_one};
    end
    if (cmd.y_en) begin
      y <= y_next;
      y_clip <= y_clip_next;
    end
    if (cmd.t1_en) begin
      t1 <= {sc[SW-1], sc} + {delay_two[SW-1], delay_two};
    end
    if (cmd.t2_en) begin
      t2 <= sc;
    end
    if (cmd.out_load) begin
      sample_out <= y;
      clipped <= y_clip;
    end
  end

endmodule

>>> bench/tb_biquad_bandpass_filter.sv
// Self-checking testbench of the biquad section: random handshakes, coefficient sweeps, predictor.
`timescale 1ns / 1ps

module tb_biquad_bandpass_filter;

  localparam int SW = bbf_pkg::SAMPLE_WIDTH_DEF;
  localparam int COEF_W = bbf_pkg::COEF_W;
  localparam int CFG_INDEX_W = bbf_pkg::CFG_INDEX_W;
  localparam int STATE_W = bbf_pkg::STATE_W;
  localparam int STATE_FRAC = bbf_pkg::STATE_FRAC;
  localparam int COEF_FRAC_BITS_DEF = bbf_pkg::COEF_FRAC_BITS_DEF;
  localparam int PROD_SHIFT = COEF_FRAC_BITS_DEF - STATE_FRAC;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 103;
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS_DEF;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 start;
  } in_word_t;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          clip;
  } out_word_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [COEF_W-1:0]      data;
  } cfg_word_t;

  typedef enum int {STYLE_BANDPASS, STYLE_RANDOM, STYLE_EXTREME, STYLE_UNITY} coef_style_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [SW-1:0]   sample_in = '0;
  logic                   block_start = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [SW-1:0]   sample_out;
  logic                   clipped;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]      cfg_data = '0;

  in_word_t  sample_q[$];
  out_word_t filtered_q[$];
  cfg_word_t coef_q[$];

  longint c_b0 = longint'(1) <<< COEF_FRAC_BITS_DEF;
  longint c_b1 = 0;
  longint c_b2 = 0;
  longint c_a1 = 0;
  longint c_a2 = 0;
  longint delay_one = 0;
  longint delay_two = 0;

  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int unsigned send_gap_max = 0;
  int unsigned recv_stall_max = 0;
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  int unsigned wait_next;
  in_word_t    next_word;
  out_word_t   want;

  biquad_bandpass_filter u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .block_start (block_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .clipped     (clipped),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint scale_prod(longint v, longint c);
    longint p;
    p = (v * c + (longint'(1) <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    return clamp(p, STATE_W);
  endfunction

  // Advances the two delay words by one sample and returns the filtered word.
  function automatic out_word_t filter_sample(logic signed [SW-1:0] x_in, logic start);
    longint    x;
    longint    acc;
    longint    y;
    longint    y_sat;
    out_word_t r;
    x = x_in;
    if (start) begin
      delay_one = 0;
      delay_two = 0;
    end
    acc = scale_prod(x, c_b0) + delay_one;
    y = (acc + (longint'(1) <<< (STATE_FRAC - 1))) >>> STATE_FRAC;
    y_sat = clamp(y, SW);
    delay_one = clamp(scale_prod(x, c_b1) + delay_two - scale_prod(y_sat, c_a1), STATE_W);
    delay_two = clamp(scale_prod(x, c_b2) - scale_prod(y_sat, c_a2), STATE_W);
    r.sample = y_sat[SW-1:0];
    r.clip = (y != y_sat);
    return r;
  endfunction

  task automatic add_word(logic signed [SW-1:0] s, logic start);
    in_word_t w;
    w.sample = s;
    w.start = start;
    sample_q.push_back(w);
  endtask

  task automatic add_coef(logic [CFG_INDEX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_word_t cw;
    cw.index = idx;
    cw.data = val;
    coef_q.push_back(cw);
  endtask

  task automatic add_coef_set(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                              logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                              logic [COEF_W-1:0] a2);
    add_coef(bbf_pkg::REG_B0, b0);
    add_coef(bbf_pkg::REG_B1, b1);
    add_coef(bbf_pkg::REG_B2, b2);
    add_coef(bbf_pkg::REG_A1, a1);
    add_coef(bbf_pkg::REG_A2, a2);
  endtask

  // Keeps valid high across back-to-back register writes.
  task automatic write_coefs();
    cfg_word_t cw;
    while (coef_q.size() != 0) begin
      cw = coef_q.pop_front();
      cfg_index <= cw.index;
      cfg_data <= cw.data;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (cw.index)
        bbf_pkg::REG_B0: c_b0 = $signed(cw.data);
        bbf_pkg::REG_B1: c_b1 = $signed(cw.data);
        bbf_pkg::REG_B2: c_b2 = $signed(cw.data);
        bbf_pkg::REG_A1: c_a1 = $signed(cw.data);
        bbf_pkg::REG_A2: c_a2 = $signed(cw.data);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 4))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      3: return COEF_ONE;
      default: return -COEF_ONE;
    endcase
  endfunction

  task automatic pick_coefs();
    coef_style_t style;
    longint      a2;
    longint      lim;
    longint      a1;
    longint      g;
    style = coef_style_t'($urandom_range(0, 3));
    case (style)
      STYLE_BANDPASS: begin
        // Stable pole pair inside the stability triangle, zeros at DC and Nyquist.
        a2 = $urandom_range(0, 1020054732);
        lim = (longint'(1) <<< COEF_FRAC_BITS_DEF) + a2 - 1;
        a1 = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        g = $urandom_range(0, 32'(COEF_ONE));
        add_coef_set(COEF_W'(g), '0, COEF_W'(-g), COEF_W'(a1), COEF_W'(a2));
      end
      STYLE_RANDOM: add_coef_set($urandom, $urandom, $urandom, $urandom, $urandom);
      STYLE_EXTREME: add_coef_set(extreme_coef(), extreme_coef(), extreme_coef(),
                                  extreme_coef(), extreme_coef());
      default: add_coef_set(COEF_ONE, '0, '0, '0, '0);
    endcase
    if ($urandom_range(0, 2) == 0)
      add_coef(CFG_INDEX_W'($urandom_range(bbf_pkg::REG_A2 + 1, (1 << CFG_INDEX_W) - 1)),
               $urandom);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        filtered_q.push_back(filter_sample(sample_in, block_start));
      if (in_valid && in_stall) begin
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (sample_q.size() != 0) begin
        next_word = sample_q.pop_front();
        sample_in <= next_word.sample;
        block_start <= next_word.start;
        in_valid <= 1'b1;
        send_gap <= $urandom_range(0, send_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      wait_next = recv_wait;
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected output word: sample %0d clipped %0b", sample_out, clipped);
        end else begin
          want = filtered_q.pop_front();
          if (sample_out !== want.sample || clipped !== want.clip) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("output word mismatch: expected sample %0d clipped %0b, got %0d %0b",
                       $signed(want.sample), want.clip, sample_out, clipped);
          end
        end
        wait_next = $urandom_range(0, recv_stall_max);
      end
      if (wait_next != 0) begin
        out_stall <= 1'b1;
        recv_wait <= wait_next - 1;
      end else begin
        out_stall <= 1'b0;
        recv_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic signed [SW-1:0] raw;
    int                   shift;
    logic                 start;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Unity pass-through after reset.
    send_gap_max = 3;
    recv_stall_max = 3;
    add_word('0, 1'b1);
    add_word(SAMPLE_MAX, 1'b0);
    add_word(SAMPLE_MIN, 1'b0);
    add_word(SW'(1), 1'b0);
    add_word(-SW'(1), 1'b0);
    add_word(SAMPLE_MAX, 1'b1);
    add_word(SW'(12345), 1'b0);
    add_word(-SW'(12345), 1'b0);
    drain();

    // Largest gains drive the output into saturation; unused indexes must be ignored.
    add_coef_set(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    for (int k = bbf_pkg::REG_A2 + 1; k < (1 << CFG_INDEX_W); k++)
      add_coef(CFG_INDEX_W'(k), $urandom);
    write_coefs();
    add_word(SAMPLE_MAX, 1'b1);
    add_word(SAMPLE_MIN, 1'b0);
    add_word(SAMPLE_MAX, 1'b0);
    add_word(SAMPLE_MIN, 1'b0);
    add_word('0, 1'b0);
    add_word(SAMPLE_MAX, 1'b1);
    add_word(-SW'(1), 1'b0);
    drain();

    add_coef_set(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    write_coefs();
    add_word(SAMPLE_MIN, 1'b1);
    add_word(SAMPLE_MAX, 1'b0);
    add_word(SAMPLE_MIN, 1'b0);
    add_word(SW'(1), 1'b0);
    add_word('0, 1'b0);
    add_word(SAMPLE_MAX, 1'b0);
    drain();

    // Feedback alone: with the feedforward gains at zero the input is not passed on and the output stays zero.
    add_coef_set('0, '0, '0, -COEF_ONE, COEF_ONE >> 1);
    write_coefs();
    add_word(SAMPLE_MAX, 1'b1);
    add_word(SAMPLE_MIN, 1'b0);
    add_word('0, 1'b0);
    add_word('0, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_max = 0; recv_stall_max = 0; end
        1: begin send_gap_max = 8; recv_stall_max = 8; end
        2: begin send_gap_max = 8; recv_stall_max = 0; end
        default: begin send_gap_max = 0; recv_stall_max = 8; end
      endcase
      pick_coefs();
      write_coefs();
      shift = 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        start = ($urandom_range(0, 24) == 0);
        if (start || n == 0)
          shift = $urandom_range(0, SW - 1);
        if ($urandom_range(0, 19) == 0) begin
          raw = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        end else begin
          raw = SW'($urandom);
          raw = raw >>> shift;
        end
        add_word(raw, start);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && filtered_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
